### rtl/core/swm_pkg.sv
// shared constants and the command type for the sliding window median filter
// used by swm_ctrl, swm_dp and sliding_window_median
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMP_W     = 32;
  localparam int MED_W      = SAMP_W + 1;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

  localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = CFG_AW'(0);

  typedef struct packed {
    logic             ld_sample;
    logic             ring_rd;
    logic             ring_wr;
    logic [IDX_W-1:0] ring_addr;
    logic             rem;
    logic             ins;
    logic [LEN_W-1:0] cnt;
    logic             rd_a;
    logic             rd_b;
    logic [IDX_W-1:0] rd_idx;
    logic             ld_out;
  } cmd_t;

endpackage

### rtl/core/swm_dp.sv
// datapath: arrival ring memory, sorted cell row, median operands and result register
// depends on swm_pkg
module swm_dp (
  input  logic                              clk,
  input  swm_pkg::cmd_t                     cmd,
  input  logic signed [swm_pkg::SAMP_W-1:0] in_sample,
  output logic signed [swm_pkg::MED_W-1:0]  med_out
);

  logic signed [swm_pkg::SAMP_W-1:0] samp_r;
  logic signed [swm_pkg::SAMP_W-1:0] old_r;
  logic signed [swm_pkg::SAMP_W-1:0] a_r;
  logic signed [swm_pkg::SAMP_W-1:0] b_r;
  logic signed [swm_pkg::MED_W-1:0]  med_r;
  logic signed [swm_pkg::MED_W-1:0]  med_nxt;

  logic signed [swm_pkg::SAMP_W-1:0] ring_mem [swm_pkg::MAX_WINDOW];
  logic signed [swm_pkg::SAMP_W-1:0] cell_r   [swm_pkg::MAX_WINDOW];
  logic signed [swm_pkg::SAMP_W-1:0] cell_nxt [swm_pkg::MAX_WINDOW];
  logic [swm_pkg::MAX_WINDOW-1:0]    gt;

  // ring: one write and one registered read per cycle, each only when its command bit is set
  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      ring_mem[cmd.ring_addr] <= samp_r;
    end
    if (cmd.ring_rd) begin
      old_r <= ring_mem[cmd.ring_addr];
    end
  end

  // sorted cells: each cell looks at its own value and its neighbors
  for (genvar gi = 0; gi < swm_pkg::MAX_WINDOW; gi++) begin : g_cell
    logic [swm_pkg::LEN_W-1:0]         pos;
    logic                              ge_old;
    logic signed [swm_pkg::SAMP_W-1:0] up_nb;
    logic signed [swm_pkg::SAMP_W-1:0] dn_nb;
    logic                              up_ok;
    logic                              dn_gt;

    assign pos    = (swm_pkg::LEN_W)'(gi);
    assign gt[gi] = (pos >= cmd.cnt) || (cell_r[gi] > samp_r);
    assign ge_old = cell_r[gi] >= old_r;

    if (gi < swm_pkg::MAX_WINDOW - 1) begin : g_up
      assign up_nb = cell_r[gi+1];
      assign up_ok = ((swm_pkg::LEN_W)'(gi + 1) < cmd.cnt);
    end else begin : g_top
      assign up_nb = cell_r[gi];
      assign up_ok = 1'b0;
    end

    if (gi > 0) begin : g_dn
      assign dn_nb = cell_r[gi-1];
      assign dn_gt = gt[gi-1];
    end else begin : g_bot
      assign dn_nb = cell_r[gi];
      assign dn_gt = 1'b0;
    end

    always_comb begin
      cell_nxt[gi] = cell_r[gi];
      if (cmd.rem && up_ok && ge_old) begin
        cell_nxt[gi] = up_nb;
      end else if (cmd.ins) begin
        if (dn_gt) begin
          cell_nxt[gi] = dn_nb;
        end else if (gt[gi]) begin
          cell_nxt[gi] = samp_r;
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[gi] <= cell_nxt[gi];
    end
  end

  // sample register, one registered read port over the cell row for the median operands, and result register
  always_ff @(posedge clk) begin
    if (cmd.ld_sample) begin
      samp_r <= in_sample;
    end
    if (cmd.rd_a) begin
      a_r <= cell_r[cmd.rd_idx];
    end
    if (cmd.rd_b) begin
      b_r <= cell_r[cmd.rd_idx];
    end
    if (cmd.ld_out) begin
      med_r <= med_nxt;
    end
  end

  assign med_nxt = {a_r[swm_pkg::SAMP_W-1], a_r} + {b_r[swm_pkg::SAMP_W-1], b_r};
  assign med_out = med_r;

endmodule

### rtl/core/swm_ctrl.sv
// controller: window length register, fill count, oldest pointer and sequencing fsm
// depends on swm_pkg
module swm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swm_pkg::LEN_W-1:0]    cfg_len,
  output logic [swm_pkg::LEN_W-1:0]    len_reg,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output swm_pkg::cmd_t                cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REM  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [swm_pkg::LEN_W-1:0] wl_r, wl_nxt;
  logic [swm_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic [swm_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic                      steady_r, steady_nxt;
  logic                      ovalid_r, ovalid_nxt;

  logic [swm_pkg::LEN_W-1:0] len;
  logic [swm_pkg::LEN_W-1:0] ptr_inc;
  logic [swm_pkg::IDX_W-1:0] half;
  logic                      accept;

  always_comb begin
    if (wl_r == '0) begin
      len = swm_pkg::LEN_W'(1);
    end else if (wl_r > swm_pkg::LEN_MAX) begin
      len = swm_pkg::LEN_MAX;
    end else begin
      len = wl_r;
    end
  end

  assign half     = len[swm_pkg::LEN_W-1:1];
  assign ptr_inc  = {1'b0, ptr_r} + swm_pkg::LEN_W'(1);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign len_reg  = wl_r;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    wl_nxt     = wl_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    steady_nxt = steady_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        cmd.ring_addr = ptr_r;
        if (accept) begin
          cmd.ld_sample = 1'b1;
          if (fill_r == len) begin
            cmd.ring_rd = 1'b1;
            steady_nxt  = 1'b1;
            state_nxt   = S_REM;
          end else begin
            steady_nxt = 1'b0;
            state_nxt  = S_INS;
          end
        end
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        cmd.cnt   = len;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins     = 1'b1;
        cmd.ring_wr = 1'b1;
        if (steady_r) begin
          cmd.cnt       = len - swm_pkg::LEN_W'(1);
          cmd.ring_addr = ptr_r;
          ptr_nxt       = (ptr_inc == len) ? '0 : ptr_inc[swm_pkg::IDX_W-1:0];
          state_nxt     = S_MLO;
        end else begin
          cmd.cnt       = fill_r;
          cmd.ring_addr = fill_r[swm_pkg::IDX_W-1:0];
          fill_nxt      = fill_r + swm_pkg::LEN_W'(1);
          ptr_nxt       = '0;
          state_nxt     = (fill_nxt == len) ? S_MLO : S_IDLE;
        end
      end
      S_MLO: begin
        cmd.rd_a   = 1'b1;
        cmd.rd_idx = len[0] ? half : half - swm_pkg::IDX_W'(1);
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.rd_b   = 1'b1;
        cmd.rd_idx = half;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!ovalid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      wl_nxt   = cfg_len;
      fill_nxt = '0;
      ptr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wl_r     <= swm_pkg::LEN_RESET;
      fill_r   <= '0;
      ptr_r    <= '0;
      steady_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wl_r     <= wl_nxt;
      fill_r   <= fill_nxt;
      ptr_r    <= ptr_nxt;
      steady_r <= steady_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### rtl/core/sliding_window_median.sv
// top level of the sliding window median filter: register port decode and channel wiring
// depends on swm_pkg, swm_ctrl, swm_dp
//
//  channel  direction  payload
//  in_      slave      tdata[31:0] sample (signed)
//  out_     master     tdata[32:0] median_doubled (signed), upper bits zero
//  cfg_     apb slave  reg 0 at 0x0: window_length[6:0]
//
// a filling item is accepted and inserted; when it fills the window, the median reads and result load follow
// a full-window item runs ring read, cell removal, cell insertion,
// two reads of the cell row through its single read port, result load
// result register frees the input while an item waits on out_tready
// rst_n empties the window and sets window_length to 3; a length write empties it too
module sliding_window_median (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // median_doubled, zero fill
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [swm_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [swm_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [swm_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  swm_pkg::cmd_t                     cmd;
  logic                              cfg_we;
  logic                              sel_len;
  logic [swm_pkg::LEN_W-1:0]         len_reg;
  logic signed [swm_pkg::MED_W-1:0]  med;

  assign sel_len    = (cfg_paddr[swm_pkg::CFG_AW-1] == swm_pkg::REG_WINDOW_LENGTH[swm_pkg::CFG_AW-1]);
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_len;

  always_comb begin
    cfg_prdata = '0;
    if (sel_len) begin
      cfg_prdata = {{(swm_pkg::CFG_DW - swm_pkg::LEN_W){1'b0}}, len_reg};
    end
  end

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_len   (cfg_pwdata[swm_pkg::LEN_W-1:0]),
    .len_reg   (len_reg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  swm_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_sample (in_tdata),
    .med_out   (med)
  );

  assign out_tdata = {{(40 - swm_pkg::MED_W){1'b0}}, med};

endmodule

### tb/tb.sv
// testbench for sliding_window_median: directed and random sample streams with
// random stalls, length register writes and an internal running-median predictor
// depends on swm_pkg and the sliding_window_median rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               CLK_PERIOD   = 10;
  localparam int               SETTLE_TICKS = 16;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam int               SAMP_MIN     = 32'sh8000_0000;
  localparam int               SAMP_MAX     = 32'sh7fff_ffff;
  localparam logic [swm_pkg::CFG_AW-1:0] ADDR_UNUSED = (swm_pkg::CFG_AW)'(4);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata = '0;      // sample
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [39:0]                out_tdata;          // median_doubled[32:0], zero fill
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [swm_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [swm_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [swm_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  sliding_window_median DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  logic [39:0] median_q[$];

  logic signed [31:0] arrival_m [swm_pkg::MAX_WINDOW];
  logic signed [31:0] ranked_m [swm_pkg::MAX_WINDOW];
  int                 fill_m = 0;
  int                 oldest_m = 0;
  logic [6:0]         length_reg = swm_pkg::LEN_RESET;

  function automatic int active_length();
    if (length_reg == 7'd0) return 1;
    if (int'(length_reg) > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
    return int'(length_reg);
  endfunction

  function automatic void ranked_insert(input logic signed [31:0] v, input int n);
    int i;
    i = n;
    while (i > 0 && ranked_m[i-1] > v) begin
      ranked_m[i] = ranked_m[i-1];
      i--;
    end
    ranked_m[i] = v;
  endfunction

  function automatic void ranked_remove(input logic signed [31:0] v, input int n);
    int i;
    i = 0;
    while (i < n && ranked_m[i] != v) i++;
    if (i < n) begin
      while (i + 1 < n) begin
        ranked_m[i] = ranked_m[i+1];
        i++;
      end
    end
  endfunction

  function automatic void track_sample(input logic signed [31:0] s);
    int     n;
    int     p;
    longint twice;
    n = active_length();
    if (fill_m < n) begin
      arrival_m[fill_m] = s;
      ranked_insert(s, fill_m);
      fill_m++;
      oldest_m = 0;
    end else begin
      p = (oldest_m >= n) ? 0 : oldest_m;
      ranked_remove(arrival_m[p], n);
      ranked_insert(s, n - 1);
      arrival_m[p] = s;
      oldest_m = (p + 1 >= n) ? 0 : p + 1;
    end
    if (fill_m >= n) begin
      if (n % 2 == 1)
        twice = 2 * longint'(ranked_m[n/2]);
      else
        twice = longint'(ranked_m[n/2-1]) + longint'(ranked_m[n/2]);
      median_q.insert(median_q.size(), {7'd0, twice[32:0]});
    end
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [39:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected median item, expected none, actual %h", $time, out_tdata);
      end else begin
        want = median_q.pop_front();
        if (out_tdata !== want) begin
          errors++;
          $display("%0t: median mismatch, expected %h, actual %h", $time, want, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [31:0] s);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_sample(s);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_length(input logic [swm_pkg::CFG_AW-1:0] addr,
                              input logic [swm_pkg::CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == swm_pkg::REG_WINDOW_LENGTH) begin
      length_reg = val[6:0];
      fill_m     = 0;
      oldest_m   = 0;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_length_reg();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= swm_pkg::REG_WINDOW_LENGTH;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[6:0] !== length_reg) begin
      errors++;
      $display("%0t: window_length readback, expected %h, actual %h",
               $time, length_reg, cfg_prdata[6:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return 32'($signed($urandom_range(0, 8)) - 4);
    if (r == 7) return SAMP_MAX - $urandom_range(0, 1);
    if (r == 8) return SAMP_MIN + $urandom_range(0, 1);
    return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
  endfunction

  task automatic test_default_length();
    int vals [10] = '{SAMP_MIN, SAMP_MAX, SAMP_MIN, SAMP_MIN, 0, -1, 5, 5, 5, 7};
    check_length_reg();
    foreach (vals[i]) push_sample(vals[i]);
    wait_idle();
  endtask

  task automatic test_even_extremes();
    int vals [6] = '{SAMP_MAX, SAMP_MAX, SAMP_MIN, SAMP_MIN, -1, 0};
    write_length(swm_pkg::REG_WINDOW_LENGTH, 32'd2);
    foreach (vals[i]) push_sample(vals[i]);
    wait_idle();
  endtask

  task automatic test_length_zero();
    int vals [3] = '{-7, 42, SAMP_MIN};
    write_length(swm_pkg::REG_WINDOW_LENGTH, 32'd0);
    check_length_reg();
    foreach (vals[i]) push_sample(vals[i]);
    wait_idle();
  endtask

  task automatic test_unmapped_write();
    int vals [6] = '{1, 2, 3, 4, 4, -9};
    write_length(swm_pkg::REG_WINDOW_LENGTH, 32'd4);
    for (int i = 0; i < 3; i++) push_sample(vals[i]);
    wait_idle();
    // must neither change the length nor empty the window
    write_length(ADDR_UNUSED, 32'd1);
    check_length_reg();
    for (int i = 3; i < 6; i++) push_sample(vals[i]);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_length(swm_pkg::REG_WINDOW_LENGTH, 32'd5);
    @(negedge clk);
    hold_left = 250;
    @(posedge clk);
    repeat (45) push_sample(pick_sample());
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int          sent;
    int          r;
    int          burst;
    logic [6:0]  want_len;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        want_len = 7'(swm_pkg::MAX_WINDOW);
      else if (r == 1)
        want_len = 7'($urandom_range(swm_pkg::MAX_WINDOW + 1, 127));
      else if (r == 2)
        want_len = 7'd0;
      else
        want_len = 7'($urandom_range(1, 16));
      write_length(swm_pkg::REG_WINDOW_LENGTH, {25'($urandom), want_len});
      check_length_reg();
      burst = active_length() + $urandom_range(8, 40);
      repeat (burst) push_sample(pick_sample());
      sent += burst;
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_length();
    test_even_extremes();
    test_length_zero();
    test_unmapped_write();
    test_backpressure();
    test_random_traffic(27, 60, 340);
    test_random_traffic(60, 27, 340);
    test_random_traffic(0, 0, 340);

    wait_idle();
    if (errors == 0 && median_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/swm_pkg.sv
rtl/core/swm_dp.sv
rtl/core/swm_ctrl.sv
rtl/core/sliding_window_median.sv
tb/tb.sv
